### sv/assert_macros.svh
// assertion macros used by the array table rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### sv/atids_pkg.sv
// shared types and constants for the array table block
// no dependencies
`default_nettype none
package atids_pkg;
    localparam int CAPACITY_DEF = 64;
    localparam int VAL_W = 32;
    localparam int OUT_W = 7;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_DELETE = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEL_RD,
        S_DEL_CMP,
        S_SH_RD,
        S_SH_WR,
        S_SO_RDI,
        S_SO_RDJ,
        S_SO_CMP,
        S_SO_WRJ,
        S_BS_RD,
        S_BS_CMP,
        S_DONE
    } state_t;

    function automatic logic sgn_gt(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        return $signed(a) > $signed(b);
    endfunction
endpackage
`default_nettype wire

### sv/array_table_insert_delete_search.sv
// array table: append, delete, clear, sort-and-search over a value store
// append and clear go straight to the done state; delete scans for the key
// then shifts the later entries down (one ram access per cycle); search first
// runs the single-port exchange sort (skipped for a single entry), then a binary search, a read and a compare per probe
// one item at a time; the result word waits in an output register
// rst_n clears the fill count and control; store contents stay undefined
`default_nettype none
`include "assert_macros.svh"
module array_table_insert_delete_search
    import atids_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        opcode,
    input  wire logic signed [31:0] operand_value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             status,
    output logic [OUT_W-1:0]       found_position,
    output logic [OUT_W-1:0]       fill_count
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;       // fill count
    logic [VAL_W-1:0] key_reg, key_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [VAL_W-1:0] vi_reg, vi_next, vj_reg, vj_next;
    // binary search bounds, one extra bit for the signed empty interval
    logic signed [CW:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [1:0]    st_reg, st_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          ov_reg, ov_next;

    // ram port
    logic          we;
    logic [AW-1:0] addr;
    logic [VAL_W-1:0] wdata, rdata;
    logic signed [CW+1:0] mid_sum;
    logic signed [CW:0] mid;

    atids_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // probe midpoint, sum kept one bit wider so it cannot wrap
    assign mid_sum = lo_reg + hi_reg;
    assign mid = (CW+1)'(mid_sum >>> 1);
    assign in_stall = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign status = st_reg;
    assign found_position = OUT_W'(pos_reg);
    assign fill_count = OUT_W'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        vi_reg  <= vi_next;
        vj_reg  <= vj_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        st_reg  <= st_next;
        pos_reg <= pos_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    unique case (op_t'(opcode))
                        OP_CLEAR, OP_APPEND: state_next = S_DONE;
                        OP_DELETE: state_next = (cnt_reg == '0) ? S_DONE : S_DEL_RD;
                        OP_SEARCH:
                        begin
                            if (cnt_reg == '0)
                                state_next = S_DONE;
                            else if (cnt_reg == CW'(1))
                                state_next = S_BS_RD;
                            else
                                state_next = S_SO_RDI;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_DEL_RD:  state_next = S_DEL_CMP;
            S_DEL_CMP:
            begin
                if (rdata == key_reg)
                    state_next = (i_reg + CW'(1) < cnt_reg) ? S_SH_RD : S_DONE;
                else
                    state_next = (i_reg + CW'(1) < cnt_reg) ? S_DEL_RD : S_DONE;
            end
            S_SH_RD:   state_next = S_SH_WR;
            // fill count already holds the reduced value here
            S_SH_WR:   state_next = (i_reg + CW'(1) < cnt_reg) ? S_SH_RD : S_DONE;
            S_SO_RDI:  state_next = S_SO_RDJ;
            S_SO_RDJ:  state_next = S_SO_CMP;
            S_SO_CMP:
            begin
                if (sgn_gt(vi_reg, rdata))
                    state_next = S_SO_WRJ;
                else if (j_reg + CW'(1) < cnt_reg)
                    state_next = S_SO_RDJ;
                else
                    state_next = (i_reg + CW'(2) < cnt_reg) ? S_SO_RDI : S_BS_RD;
            end
            S_SO_WRJ:
            begin
                if (j_reg + CW'(1) < cnt_reg)
                    state_next = S_SO_RDJ;
                else
                    state_next = (i_reg + CW'(2) < cnt_reg) ? S_SO_RDI : S_BS_RD;
            end
            S_BS_RD:   state_next = S_BS_CMP;
            S_BS_CMP:
            begin
                if (rdata == key_reg)
                    state_next = S_DONE;
                else if (sgn_gt(key_reg, rdata))
                    state_next = (mid + 1 <= hi_reg) ? S_BS_RD : S_DONE;
                else
                    state_next = (lo_reg <= mid - 1) ? S_BS_RD : S_DONE;
            end
            S_DONE:    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next = cnt_reg;
        key_next = key_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        vi_next  = vi_reg;
        vj_next  = vj_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        st_next  = st_reg;
        pos_next = pos_reg;
        ov_next  = ov_reg && out_stall;
        we    = 1'b0;
        addr  = AW'(i_reg);
        wdata = vi_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    key_next = operand_value;
                    i_next   = '0;
                    j_next   = CW'(1);
                    pos_next = '0;
                    st_next  = ST_OK;
                    lo_next  = '0;
                    hi_next  = (CW+1)'($signed({1'b0, cnt_reg}) - 1);
                    unique case (op_t'(opcode))
                        OP_CLEAR: cnt_next = '0;
                        OP_APPEND:
                        begin
                            if (cnt_reg >= CW'(CAPACITY))
                                st_next = ST_FULL;
                            else
                            begin
                                we = 1'b1;
                                addr = AW'(cnt_reg);
                                wdata = operand_value;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                                st_next = ST_EMPTY;
                            else
                                st_next = ST_MISSING;
                        end
                    endcase
                end
            end
            S_DEL_RD:  addr = AW'(i_reg);
            S_DEL_CMP:
            begin
                if (rdata == key_reg)
                begin
                    st_next = ST_OK;
                    cnt_next = cnt_reg - CW'(1);
                end
                else
                    i_next = i_reg + CW'(1);
            end
            S_SH_RD:   addr = AW'(i_reg + CW'(1));
            S_SH_WR:
            begin
                we = 1'b1;
                addr = AW'(i_reg);
                wdata = rdata;
                i_next = i_reg + CW'(1);
            end
            S_SO_RDI:
            begin
                addr = AW'(i_reg);
                j_next = i_reg + CW'(1);
            end
            S_SO_RDJ:
            begin
                addr = AW'(j_reg);
                if (j_reg == i_reg + CW'(1))
                    vi_next = rdata;
            end
            S_SO_CMP:
            begin
                if (sgn_gt(vi_reg, rdata))
                begin
                    // store smaller at i now, larger at j next cycle
                    we = 1'b1;
                    addr = AW'(i_reg);
                    wdata = rdata;
                    vj_next = vi_reg;
                    vi_next = rdata;
                end
                else if (j_reg + CW'(1) < cnt_reg)
                    j_next = j_reg + CW'(1);
                else
                    i_next = i_reg + CW'(1);
            end
            S_SO_WRJ:
            begin
                we = 1'b1;
                addr = AW'(j_reg);
                wdata = vj_reg;
                if (j_reg + CW'(1) < cnt_reg)
                    j_next = j_reg + CW'(1);
                else
                    i_next = i_reg + CW'(1);
            end
            S_BS_RD:   addr = AW'(mid[CW-1:0]);
            S_BS_CMP:
            begin
                addr = AW'(mid[CW-1:0]);
                if (rdata == key_reg)
                begin
                    st_next = ST_OK;
                    pos_next = mid[CW-1:0] + CW'(1);
                end
                else if (sgn_gt(key_reg, rdata))
                    lo_next = (CW+1)'(mid + 1);
                else
                    hi_next = (CW+1)'(mid - 1);
            end
            S_DONE:    ov_next = 1'b1;
            default:   ov_next = ov_reg && out_stall;
        endcase
    end

    // the fill count never passes the capacity
    `ASSERT_NEVER(a_cnt_cap, clk, rst_n, cnt_reg > CW'(CAPACITY))
    // no new word while a result is still held
    `ASSERT_NEVER(a_no_accept_busy, clk, rst_n, ov_reg && !in_stall)
    // a result word leaves only from the done state
    `ASSERT_IMPL(a_done_out, clk, rst_n, $rose(ov_reg) |-> $past(state_reg) == S_DONE)
    // ram writes outside the idle state stay below the fill count
    `ASSERT_NEVER(a_wr_range, clk, rst_n, we && state_reg != S_IDLE && {1'b0, addr} >= cnt_reg)
endmodule
`default_nettype wire

### sv/atids_ram.sv
// generic single port ram with registered read
// no dependencies
`default_nettype none
module atids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### sim/atids_checker.sv
// checker for the array table block: watches both channels, predicts each result word
// depends on atids_pkg
`timescale 1ns / 1ps
module atids_checker
    import atids_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [31:0]       operand_value,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [1:0]        status,
    input  logic [OUT_W-1:0]  found_position,
    input  logic [OUT_W-1:0]  fill_count,
    output int                fail_count,
    output int                pending_count
);
    typedef struct packed {
        logic [1:0]       status;
        logic [OUT_W-1:0] pos;
        logic [OUT_W-1:0] fill;
    } table_result_t;

    logic signed [31:0] shadow_store [CAPACITY];
    int                 shadow_fill;
    table_result_t      expected_q [$];

    assign pending_count = expected_q.size();

    function automatic table_result_t apply_table_op(op_t op, logic signed [31:0] v);
        table_result_t      r;
        logic signed [31:0] t;
        int                 lo;
        int                 hi;
        int                 mid;
        bit                 hit;
        r.status = ST_OK;
        r.pos = '0;
        case (op)
            OP_CLEAR: shadow_fill = 0;
            OP_APPEND:
                if (shadow_fill >= CAPACITY) r.status = ST_FULL;
                else
                begin
                    shadow_store[shadow_fill] = v;
                    shadow_fill++;
                end
            OP_DELETE:
                if (shadow_fill == 0) r.status = ST_EMPTY;
                else
                begin
                    r.status = ST_MISSING;
                    for (int i = 0; i < shadow_fill; i++)
                        if (shadow_store[i] == v)
                        begin
                            for (int j = i; j + 1 < shadow_fill; j++)
                                shadow_store[j] = shadow_store[j+1];
                            shadow_fill--;
                            r.status = ST_OK;
                            break;
                        end
                end
            default:
                if (shadow_fill == 0) r.status = ST_EMPTY;
                else
                begin
                    // exchange sort, left sorted
                    for (int i = 0; i + 1 < shadow_fill; i++)
                        for (int j = i + 1; j < shadow_fill; j++)
                            if (shadow_store[i] > shadow_store[j])
                            begin
                                t = shadow_store[i];
                                shadow_store[i] = shadow_store[j];
                                shadow_store[j] = t;
                            end
                    lo = 0;
                    hi = shadow_fill - 1;
                    hit = 0;
                    r.status = ST_MISSING;
                    while (lo <= hi && !hit)
                    begin
                        mid = (lo + hi) / 2;
                        if (shadow_store[mid] == v)
                        begin
                            hit = 1;
                            r.status = ST_OK;
                            r.pos = OUT_W'(mid + 1);
                        end
                        else if (shadow_store[mid] < v) lo = mid + 1;
                        else hi = mid - 1;
                    end
                end
        endcase
        r.fill = OUT_W'(shadow_fill);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t e;
        if (!rst_n)
        begin
            shadow_fill <= 0;
            fail_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_q.push_back(apply_table_op(op_t'(opcode), operand_value));
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected word st=%0d pos=%0d fill=%0d", $time,
                             status, found_position, fill_count);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.status !== status || e.pos !== found_position
                        || e.fill !== fill_count)
                    begin
                        $display({"%0t: expected st=%0d pos=%0d fill=%0d,",
                                  " actual st=%0d pos=%0d fill=%0d"},
                                 $time, e.status, e.pos, e.fill, status, found_position,
                                 fill_count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### sim/tb_top.sv
// top of the array table testbench: clock, reset, stimulus, verdict
// depends on atids_pkg, the block and atids_checker
`timescale 1ns / 1ps
module tb_top;
    import atids_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int IDLE_LIMIT = 60000;   // limit well above the longest search sort

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [31:0] operand_value;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [OUT_W-1:0] found_position;
    logic [OUT_W-1:0] fill_count;
    int          fail_count;
    int          pending_count;
    int          quiet_cycles;
    bit          calm_phase;     // stretch with no idling on either side
    bit          hold_receiver;  // long receiver hold-off
    logic [31:0] recent_vals [8];

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    array_table_insert_delete_search #(.CAPACITY(CAP)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .operand_value(operand_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .found_position(found_position), .fill_count(fill_count)
    );

    atids_checker #(.CAPACITY(CAP)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .operand_value(operand_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .found_position(found_position), .fill_count(fill_count),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // offer one word, with a random idle gap first outside the calm stretch, and wait until it is taken
    // valid stays high after the handshake unless the next call idles
    task automatic send_word(op_t op, logic [31:0] v);
        if (!calm_phase)
            while ($urandom_range(99) < 37)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        opcode <= op;
        operand_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // values mostly drawn from a small pool so deletes and searches hit often
    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return recent_vals[$urandom_range(7)];
            default: return 32'($signed($urandom_range(20)) - 10);
        endcase
    endfunction

    task automatic send_random(int n);
        int          r;
        logic [31:0] v;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            v = pick_value();
            recent_vals[$urandom_range(7)] = v;
            if (r < 3) send_word(OP_CLEAR, $urandom());
            else if (r < 50) send_word(OP_APPEND, v);
            else if (r < 72) send_word(OP_DELETE, v);
            else send_word(OP_SEARCH, v);
        end
    endtask

    // receiver stall: random, except in the calm stretch or the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else
            out_stall <= hold_receiver || (!calm_phase && ($urandom_range(99) < 37));
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT)
        begin
            $display("array_table_insert_delete_search: mismatch");
            $finish;
        end
    end

    // long hold-off counted here while the sender keeps offering
    initial
    begin
        hold_receiver = 1'b0;
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_receiver = 1'b1;
        repeat (400) @(posedge clk);
        hold_receiver = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_CLEAR;
        operand_value = '0;
        calm_phase = 1'b0;
        for (int k = 0; k < 8; k++)
            recent_vals[k] = 32'(k);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, duplicates, no match
        send_word(OP_DELETE, 32'h0000_0005);
        send_word(OP_SEARCH, 32'h0000_0005);
        send_word(OP_APPEND, 32'h7fff_ffff);
        send_word(OP_APPEND, 32'h8000_0000);
        send_word(OP_APPEND, 32'hffff_ffff);
        send_word(OP_APPEND, 32'h0000_0000);
        send_word(OP_APPEND, 32'h0000_0003);
        send_word(OP_APPEND, 32'h0000_0003);
        send_word(OP_SEARCH, 32'h8000_0000);
        send_word(OP_SEARCH, 32'h7fff_ffff);
        send_word(OP_SEARCH, 32'h0000_0003);
        send_word(OP_SEARCH, 32'h1234_5678);
        send_word(OP_DELETE, 32'h5555_5555);
        send_word(OP_DELETE, 32'h0000_0003);
        send_word(OP_DELETE, 32'h8000_0000);
        send_word(OP_CLEAR, 32'haaaa_aaaa);
        // fill to capacity, then overflow
        calm_phase = 1'b1;
        for (int k = 0; k < CAP; k++)
            send_word(OP_APPEND, $urandom());
        send_word(OP_APPEND, 32'h0f0f_0f0f);
        send_word(OP_SEARCH, 32'hffff_ffff);
        calm_phase = 1'b0;
        send_word(OP_CLEAR, 32'h0);

        send_random(110);
        calm_phase = 1'b1;
        send_random(30);
        calm_phase = 1'b0;
        send_random(67);
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("array_table_insert_delete_search: match");
        else
            $display("array_table_insert_delete_search: mismatch");
        $finish;
    end
endmodule
